// File: design/clm_pkg.sv
// shared types, constants and codes of the circular list manager
package clm_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ELEM_W       = 32;
    localparam int FUNC_W       = 3;
    localparam int POS_W        = 7;
    localparam int ROT_W        = 16;
    localparam int STAT_W       = 3;
    localparam int CNT_W        = 7;
    localparam int BCNT_W       = $clog2(ROT_W);
    localparam int S_TDATA_W    = ((POS_W + ELEM_W + ROT_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((ELEM_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT   = 3'd0,
        FN_READ     = 3'd1,
        FN_REMOVE   = 3'd2,
        FN_MATCH    = 3'd3,
        FN_REVERSE  = 3'd4,
        FN_ROTATE   = 3'd5
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_POS   = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TAKE_WT,
        S_MOD,
        S_WALK_GO,
        S_WALK,
        S_FIN1,
        S_FIN2,
        S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic take_pop;
        logic mod_step;
        logic walk_start;
        logic walk;
        logic fin1;
        logic fin2;
        logic respond;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        func_t   func;
        status_t chk;
        logic    empty;
        logic    pop_read;
        logic    mod_done;
        logic    hit;
        logic    miss;
        logic    out_free;
    } sts_t;

endpackage

// File: design/circular_list_manager_top.sv
// top level of the circular list manager
//
// usage: one command transfer on the s_axis channel (operation code in tuser,
// position, value and rotate count in tdata) gives exactly one result transfer
// on the m_axis channel (status in tuser, element and resulting count in tdata)
// the list lives in two stores of CAPACITY slots: element data and successor
// links; a tail pointer, a length, a free slot stack threaded through the
// link store and a first-never-used mark complete the state
// walking: operations that follow links walk one link a cycle through the
// link store's registered read port, up to the length and at most CAPACITY
// links; insert, remove and a found match then update links in FIN1 and FIN2,
// an insert that pops a stacked slot first reads its link in S_TAKE_WT, and
// rotate first reduces its count modulo the length one bit a cycle; an insert
// into an empty list walks nothing; status errors, unused codes and reverse or
// rotate of an empty list answer without walking
// one item is worked at a time; s_axis_tready is high only while idle
// the result sits in an output register, so a stalled receiver holds the next
// item only at its response step; payload holds while m_axis_tvalid is
// high and m_axis_tready low
// reset: the list is empty, the free stack empty and no result pending; no
// clearing pass is needed since unwritten slots are never read
module circular_list_manager_top #(
    parameter int CAPACITY = clm_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // position, value, rotate_count, zero fill
    input  logic [clm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func
    input  logic [clm_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // data, count, zero fill
    output logic [clm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [clm_pkg::STAT_W-1:0]    m_axis_tuser
);

    localparam int POS_W = clm_pkg::POS_W;
    localparam int EW    = clm_pkg::ELEM_W;
    localparam int RW    = clm_pkg::ROT_W;
    localparam int CNT_W = clm_pkg::CNT_W;

    clm_pkg::cmd_t cmd;
    clm_pkg::sts_t sts;

    logic [EW-1:0]    res_data;
    logic [CNT_W-1:0] res_count;

    // controller: command sequencing only
    clm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: stores, walker, remainder unit and result register
    clm_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_func         (s_axis_tuser),
        .in_position     (s_axis_tdata[POS_W-1:0]),
        .in_value        (s_axis_tdata[POS_W +: EW]),
        .in_rotate_count (s_axis_tdata[POS_W + EW +: RW]),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_data        (res_data),
        .out_status      (m_axis_tuser),
        .out_count       (res_count)
    );

    assign m_axis_tdata = clm_pkg::M_TDATA_W'({res_count, res_data});

endmodule

// File: design/clm_ram.sv
// generic simple dual port ram with registered read
module clm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/clm_ctrl.sv
// sequencing state machine of the circular list manager
module clm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  clm_pkg::sts_t sts,
    output clm_pkg::cmd_t cmd
);

    clm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            clm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = clm_pkg::S_DECODE;
                end
            end
            clm_pkg::S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.chk != clm_pkg::STAT_OK)
                begin
                    state_next = clm_pkg::S_RESP;
                end
                else
                begin
                    priority case (sts.func)
                        clm_pkg::FN_INSERT:
                        begin
                            if (sts.pop_read)
                                state_next = clm_pkg::S_TAKE_WT;
                            else if (sts.empty)
                                state_next = clm_pkg::S_FIN1;
                            else
                                state_next = clm_pkg::S_WALK_GO;
                        end
                        clm_pkg::FN_READ, clm_pkg::FN_REMOVE, clm_pkg::FN_MATCH:
                            state_next = clm_pkg::S_WALK_GO;
                        clm_pkg::FN_REVERSE:
                            state_next = sts.empty ? clm_pkg::S_RESP : clm_pkg::S_WALK_GO;
                        clm_pkg::FN_ROTATE:
                            state_next = sts.empty ? clm_pkg::S_RESP : clm_pkg::S_MOD;
                        default:
                            state_next = clm_pkg::S_RESP;
                    endcase
                end
            end
            clm_pkg::S_TAKE_WT:
            begin
                cmd.take_pop = 1'b1;
                state_next   = sts.empty ? clm_pkg::S_FIN1 : clm_pkg::S_WALK_GO;
            end
            clm_pkg::S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done)
                    state_next = clm_pkg::S_WALK_GO;
            end
            clm_pkg::S_WALK_GO:
            begin
                cmd.walk_start = 1'b1;
                state_next     = clm_pkg::S_WALK;
            end
            clm_pkg::S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.hit)
                begin
                    if (sts.func == clm_pkg::FN_INSERT || sts.func == clm_pkg::FN_REMOVE
                        || sts.func == clm_pkg::FN_MATCH)
                        state_next = clm_pkg::S_FIN1;
                    else
                        state_next = clm_pkg::S_RESP;
                end
                else if (sts.miss)
                begin
                    state_next = clm_pkg::S_RESP;
                end
            end
            clm_pkg::S_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = clm_pkg::S_FIN2;
            end
            clm_pkg::S_FIN2:
            begin
                cmd.fin2   = 1'b1;
                state_next = clm_pkg::S_RESP;
            end
            clm_pkg::S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = clm_pkg::S_IDLE;
                end
            end
            default:
                state_next = clm_pkg::S_IDLE;
        endcase
    end

endmodule

// File: design/clm_dp.sv
// datapath: list registers, link walker, modulo unit, stores and result register
module clm_dp #(
    parameter int CAPACITY = clm_pkg::CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  clm_pkg::cmd_t              cmd,
    output clm_pkg::sts_t              sts,
    input  logic [clm_pkg::FUNC_W-1:0] in_func,
    input  logic [clm_pkg::POS_W-1:0]  in_position,
    input  logic [clm_pkg::ELEM_W-1:0] in_value,
    input  logic [clm_pkg::ROT_W-1:0]  in_rotate_count,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [clm_pkg::ELEM_W-1:0] out_data,
    output logic [clm_pkg::STAT_W-1:0] out_status,
    output logic [clm_pkg::CNT_W-1:0]  out_count
);

    localparam int PW     = $clog2(CAPACITY);
    localparam int LW     = $clog2(CAPACITY + 1);
    localparam int CW     = ((LW > clm_pkg::POS_W) ? LW : clm_pkg::POS_W) + 1;
    localparam int EW     = clm_pkg::ELEM_W;
    localparam int RW     = clm_pkg::ROT_W;
    localparam int BW     = clm_pkg::BCNT_W;
    localparam int CNT_W  = clm_pkg::CNT_W;

    // control registers
    logic [PW-1:0]    tail_reg, tail_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [PW-1:0]    ftop_reg, ftop_next;
    logic             fvld_reg, fvld_next;
    logic [LW-1:0]    unused_reg, unused_next;
    logic             out_vld_reg, out_vld_next;

    // payload registers
    clm_pkg::func_t   func_reg, func_next;
    logic [clm_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [EW-1:0]    val_reg, val_next;
    logic [RW-1:0]    rot_sh_reg, rot_sh_next;
    logic [LW-1:0]    rem_reg, rem_next;
    logic [BW-1:0]    bcnt_reg, bcnt_next;
    logic [PW-1:0]    hole_reg, hole_next;
    logic [PW-1:0]    prev_reg, prev_next;
    logic [PW-1:0]    cur_reg, cur_next;
    logic [PW-1:0]    nxt_reg, nxt_next;
    logic [LW-1:0]    cnt_reg, cnt_next;
    logic [EW-1:0]    data_reg, data_next;
    clm_pkg::status_t stat_reg, stat_next;
    logic [EW-1:0]    out_data_reg, out_data_next;
    clm_pkg::status_t out_stat_reg, out_stat_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;

    // store ports
    logic             lk_we;
    logic [PW-1:0]    lk_waddr, lk_wdata, lk_q;
    logic             el_we;
    logic [EW-1:0]    el_q;
    logic [PW-1:0]    rd_addr;

    logic [CW-1:0]    pos_c, len_c, cnt_c, tgt_ins;
    logic             empty, pop_read, hit, miss, is_rm;
    clm_pkg::status_t chk;
    logic [LW:0]      mod_t;

    clm_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (rd_addr),
        .rdata (lk_q)
    );

    clm_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_elem_ram (
        .clk   (clk),
        .we    (el_we),
        .waddr (hole_reg),
        .wdata (val_reg),
        .raddr (rd_addr),
        .rdata (el_q)
    );

    assign pos_c   = CW'(pos_reg);
    assign len_c   = CW'(len_reg);
    assign cnt_c   = CW'(cnt_reg);
    assign empty   = (len_reg == '0);
    assign is_rm   = (func_reg == clm_pkg::FN_REMOVE) || (func_reg == clm_pkg::FN_MATCH);
    // a pop needs the link of the stack top unless it is the last stacked slot
    assign pop_read = fvld_reg && !((len_c + CW'(1)) >= CW'(unused_reg));
    // append walks no links: the successor of the tail is the head
    assign tgt_ins = (pos_c == len_c) ? '0 : pos_c;

    always_comb
    begin
        chk = clm_pkg::STAT_OK;
        if (func_reg == clm_pkg::FN_INSERT)
        begin
            if (pos_c > len_c)
                chk = clm_pkg::STAT_BAD_POS;
            else if (len_c >= CW'(CAPACITY))
                chk = clm_pkg::STAT_FULL;
        end
        else if (func_reg == clm_pkg::FN_READ || func_reg == clm_pkg::FN_REMOVE)
        begin
            if (empty)
                chk = clm_pkg::STAT_EMPTY;
            else if (pos_c >= len_c)
                chk = clm_pkg::STAT_BAD_POS;
        end
        else if (func_reg == clm_pkg::FN_MATCH)
        begin
            if (empty)
                chk = clm_pkg::STAT_EMPTY;
        end
    end

    // cur_reg is the node cnt_reg links past the tail; lk_q and el_q belong to it
    always_comb
    begin
        hit = 1'b0;
        priority case (func_reg)
            clm_pkg::FN_INSERT:  hit = (cnt_c == tgt_ins);
            clm_pkg::FN_READ,
            clm_pkg::FN_REMOVE:  hit = (cnt_c == pos_c + CW'(1));
            clm_pkg::FN_MATCH:   hit = (cnt_reg != '0) && (el_q == val_reg);
            clm_pkg::FN_REVERSE: hit = (cnt_c == len_c);
            clm_pkg::FN_ROTATE:  hit = (cnt_c == CW'(rem_reg));
            default:             hit = 1'b1;
        endcase
    end

    assign miss = (func_reg == clm_pkg::FN_MATCH) && !hit && (cnt_c == len_c);

    always_comb
    begin
        sts.func     = func_reg;
        sts.chk      = chk;
        sts.empty    = empty;
        sts.pop_read = pop_read;
        sts.mod_done = (bcnt_reg == BW'(RW - 1));
        sts.hit      = hit;
        sts.miss     = miss;
        sts.out_free = !out_vld_reg || out_ready;
    end

    always_comb
    begin
        tail_next     = tail_reg;
        len_next      = len_reg;
        ftop_next     = ftop_reg;
        fvld_next     = fvld_reg;
        unused_next   = unused_reg;
        out_vld_next  = out_vld_reg;
        func_next     = func_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        rot_sh_next   = rot_sh_reg;
        rem_next      = rem_reg;
        bcnt_next     = bcnt_reg;
        hole_next     = hole_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        cnt_next      = cnt_reg;
        data_next     = data_reg;
        stat_next     = stat_reg;
        out_data_next = out_data_reg;
        out_stat_next = out_stat_reg;
        out_cnt_next  = out_cnt_reg;
        lk_we         = 1'b0;
        lk_waddr      = cur_reg;
        lk_wdata      = prev_reg;
        el_we         = 1'b0;
        mod_t         = {rem_reg, rot_sh_reg[RW-1]};
        rd_addr       = lk_q;

        if (cmd.take_pop || cmd.walk_start || cmd.decode)
            rd_addr = cmd.walk_start ? tail_reg : ftop_reg;

        if (cmd.load)
        begin
            func_next   = clm_pkg::func_t'(in_func);
            pos_next    = in_position;
            val_next    = in_value;
            rot_sh_next = in_rotate_count;
            rem_next    = '0;
            bcnt_next   = '0;
            data_next   = '0;
            stat_next   = clm_pkg::STAT_OK;
        end

        if (cmd.decode)
        begin
            stat_next = chk;
            if (func_reg == clm_pkg::FN_INSERT && chk == clm_pkg::STAT_OK)
            begin
                if (!fvld_reg)
                begin
                    hole_next   = unused_reg[PW-1:0];
                    unused_next = unused_reg + LW'(1);
                end
                else
                begin
                    hole_next = ftop_reg;
                    if (!pop_read)
                        fvld_next = 1'b0;
                end
            end
        end

        if (cmd.take_pop)
            ftop_next = lk_q;

        // restoring remainder, one quotient bit a cycle
        if (cmd.mod_step)
        begin
            if (mod_t >= {1'b0, len_reg})
                mod_t = mod_t - {1'b0, len_reg};
            rem_next    = mod_t[LW-1:0];
            rot_sh_next = rot_sh_reg << 1;
            bcnt_next   = bcnt_reg + BW'(1);
        end

        if (cmd.walk_start)
        begin
            cur_next = tail_reg;
            cnt_next = '0;
        end

        if (cmd.walk)
        begin
            // reversal turns each visited link back to its predecessor
            if (func_reg == clm_pkg::FN_REVERSE && cnt_reg != '0)
            begin
                lk_we    = 1'b1;
                lk_waddr = cur_reg;
                lk_wdata = prev_reg;
                if (cnt_reg == LW'(1))
                    tail_next = cur_reg;
            end
            if (hit)
            begin
                nxt_next = lk_q;
                if (func_reg == clm_pkg::FN_READ || is_rm)
                    data_next = el_q;
                if (func_reg == clm_pkg::FN_ROTATE)
                    tail_next = cur_reg;
            end
            else if (miss)
            begin
                stat_next = clm_pkg::STAT_NOT_FOUND;
            end
            else
            begin
                prev_next = cur_reg;
                cur_next  = lk_q;
                cnt_next  = cnt_reg + LW'(1);
            end
        end

        if (cmd.fin1)
        begin
            lk_we = 1'b1;
            if (func_reg == clm_pkg::FN_INSERT)
            begin
                lk_waddr = hole_reg;
                lk_wdata = empty ? hole_reg : nxt_reg;
                el_we    = 1'b1;
            end
            else
            begin
                lk_waddr = prev_reg;
                lk_wdata = nxt_reg;
                len_next = len_reg - LW'(1);
                if (cur_reg == tail_reg)
                    tail_next = prev_reg;
            end
        end

        if (cmd.fin2)
        begin
            if (func_reg == clm_pkg::FN_INSERT)
            begin
                lk_we    = 1'b1;
                lk_waddr = empty ? hole_reg : cur_reg;
                lk_wdata = hole_reg;
                if (pos_c == len_c)
                    tail_next = hole_reg;
                len_next = len_reg + LW'(1);
            end
            else
            begin
                // freed slot goes on the stack, linked to the old top if the stack held one
                lk_we     = fvld_reg;
                lk_waddr  = cur_reg;
                lk_wdata  = ftop_reg;
                ftop_next = cur_reg;
                fvld_next = 1'b1;
            end
        end

        if (cmd.respond)
        begin
            out_vld_next  = 1'b1;
            out_data_next = data_reg;
            out_stat_next = stat_reg;
            out_cnt_next  = CNT_W'(len_reg);
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg    <= '0;
            len_reg     <= '0;
            ftop_reg    <= '0;
            fvld_reg    <= 1'b0;
            unused_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            tail_reg    <= tail_next;
            len_reg     <= len_next;
            ftop_reg    <= ftop_next;
            fvld_reg    <= fvld_next;
            unused_reg  <= unused_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        rot_sh_reg   <= rot_sh_next;
        rem_reg      <= rem_next;
        bcnt_reg     <= bcnt_next;
        hole_reg     <= hole_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        cnt_reg      <= cnt_next;
        data_reg     <= data_next;
        stat_reg     <= stat_next;
        out_data_reg <= out_data_next;
        out_stat_reg <= out_stat_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign out_valid  = out_vld_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_stat_reg;
    assign out_count  = out_cnt_reg;

endmodule

// File: design/clm_checker.sv
// port level checks of the circular list manager, bound to the top level
module clm_checker #(
    parameter int CAPACITY = clm_pkg::CAPACITY_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [clm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [clm_pkg::STAT_W-1:0]    m_axis_tuser
);

    localparam int EW    = clm_pkg::ELEM_W;
    localparam int CNT_W = clm_pkg::CNT_W;

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a failed operation returns no data
    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != clm_pkg::STAT_OK |-> m_axis_tdata[EW-1:0] == '0)
        else $error("data on a failed operation");

    // the count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[EW +: CNT_W] <= CAPACITY)
        else $error("count above capacity");

    // one item at a time: ready drops after each accepted command
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command taken while busy");

endmodule

bind circular_list_manager_top clm_checker #(.CAPACITY(CAPACITY)) u_clm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
